[design/dhpi_pkg.sv]
// Package for the double-hash probe index block.
// Holds the command and result item types and the fixed hash constants.
package dhpi_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ATTEMPT_W = 16;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned CFG_W     = 16;

  localparam int unsigned MULT_FIRST  = 151;
  localparam int unsigned MULT_SECOND = 163;
  localparam logic [CFG_W-1:0] RESET_BUCKETS = 16'd53;

  typedef struct packed {
    logic [BYTE_W-1:0]    key_byte;
    logic                 has_byte;
    logic                 is_last;
    logic [ATTEMPT_W-1:0] attempt;
  } cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] bucket_index;
    logic [OUT_W-1:0] first_hash;
    logic [OUT_W-1:0] second_hash;
  } res_t;

endpackage

[design/dhpi_fifo.sv]
// Small synchronous FIFO used for the command and result queues.
// Standalone; no package dependencies.
module dhpi_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[design/dhpi_front.sv]
// Front end: accepts key items, drops items that carry neither byte nor key end.
// Depends on dhpi_pkg and dhpi_fifo (command queue).
module dhpi_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [dhpi_pkg::BYTE_W-1:0]         key_byte_i,
  input  logic                                has_byte_i,
  input  logic                                is_last_i,
  input  logic [dhpi_pkg::ATTEMPT_W-1:0]      attempt_i,
  output dhpi_pkg::cmd_t                      cmd_o,
  output logic                                cmd_valid_o,
  input  logic                                cmd_pop_i
);

  dhpi_pkg::cmd_t                    cmd_d;
  logic [$bits(dhpi_pkg::cmd_t)-1:0] cmd_raw;
  logic                              enq, cmd_empty;

  assign cmd_d.key_byte = key_byte_i;
  assign cmd_d.has_byte = has_byte_i;
  assign cmd_d.is_last  = is_last_i;
  assign cmd_d.attempt  = attempt_i;

  // items with no byte and no key end change nothing
  assign enq = push && !full && (has_byte_i || is_last_i);

  dhpi_fifo #(
    .WIDTH ($bits(dhpi_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (enq),
    .wr_data_i (cmd_d),
    .full_o    (full),
    .rd_en_i   (cmd_pop_i),
    .rd_data_o (cmd_raw),
    .empty_o   (cmd_empty)
  );

  assign cmd_o       = dhpi_pkg::cmd_t'(cmd_raw);
  assign cmd_valid_o = !cmd_empty;

endmodule

[design/dhpi_mod_unit.sv]
// Bit-serial remainder unit: one restoring compare/subtract step per cycle.
// Standalone; no package dependencies.
module dhpi_mod_unit #(
  parameter int unsigned DW = 34,
  parameter int unsigned MW = 16,
  parameter int unsigned CW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,  // left-aligned
  input  logic [CW-1:0] nbits_i,
  input  logic [MW-1:0] m_i,
  output logic          done_o,
  output logic [MW-1:0] rem_o
);

  logic [DW-1:0] sh_q;
  logic [MW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [MW:0]   trial, diff;
  logic [MW-1:0] rem_d;

  assign trial = {rem_q, sh_q[DW-1]};
  assign diff  = trial - {1'b0, m_i};
  assign rem_d = (trial >= {1'b0, m_i}) ? diff[MW-1:0] : trial[MW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        sh_q   <= dividend_i;
        rem_q  <= '0;
        cnt_q  <= nbits_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        sh_q  <= {sh_q[DW-2:0], 1'b0};
        rem_q <= rem_d;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[design/dhpi_back.sv]
// Back end: updates both running hashes and forms the probe index per key.
// Depends on dhpi_pkg and two dhpi_mod_unit instances.
module dhpi_back #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dhpi_pkg::cmd_t    cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  logic [((INDEX_BITS < 16) ? INDEX_BITS : 16)-1:0] m_i,
  output dhpi_pkg::res_t    res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);

  localparam int unsigned AW = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam int unsigned UW = AW + dhpi_pkg::BYTE_W;
  localparam int unsigned PW = AW + dhpi_pkg::ATTEMPT_W + 2;
  localparam int unsigned CW = $clog2(PW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_UPD_GO, S_UPD_WAIT, S_FIN_GO, S_FIN_WAIT,
    S_PMUL, S_P_GO, S_P_WAIT, S_PUSH
  } state_e;

  state_e          state_q;
  dhpi_pkg::cmd_t  cmd_q;
  logic [AW-1:0]   acc1_q, acc2_q, h1_q, h2_q, idx_q;
  logic [UW-1:0]   prod1_q, prod2_q;
  logic [PW-1:0]   prodp_q;

  logic            start_a, start_b;
  logic [PW-1:0]   div_a, div_b;
  logic [CW-1:0]   nbits;
  logic            done_a, done_b;
  logic [AW-1:0]   rem_a, rem_b;

  always_comb begin
    start_a = 1'b0;
    start_b = 1'b0;
    div_a   = '0;
    div_b   = '0;
    nbits   = '0;
    case (state_q)
      S_UPD_GO: begin
        start_a = 1'b1;
        start_b = 1'b1;
        div_a   = {prod1_q, {(PW-UW){1'b0}}};
        div_b   = {prod2_q, {(PW-UW){1'b0}}};
        nbits   = CW'(UW);
      end
      S_FIN_GO: begin
        start_a = 1'b1;
        start_b = 1'b1;
        div_a   = {acc1_q, {(PW-AW){1'b0}}};
        div_b   = {acc2_q, {(PW-AW){1'b0}}};
        nbits   = CW'(AW);
      end
      S_P_GO: begin
        start_a = 1'b1;
        div_a   = prodp_q;
        nbits   = CW'(PW);
      end
      default: begin
      end
    endcase
  end

  dhpi_mod_unit #(.DW(PW), .MW(AW), .CW(CW)) u_mod_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_a),
    .dividend_i (div_a),
    .nbits_i    (nbits),
    .m_i        (m_i),
    .done_o     (done_a),
    .rem_o      (rem_a)
  );

  dhpi_mod_unit #(.DW(PW), .MW(AW), .CW(CW)) u_mod_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_b),
    .dividend_i (div_b),
    .nbits_i    (nbits),
    .m_i        (m_i),
    .done_o     (done_b),
    .rem_o      (rem_b)
  );

  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign res_push_o = (state_q == S_PUSH) && !res_full_i;

  assign res_o.bucket_index = dhpi_pkg::OUT_W'(idx_q);
  assign res_o.first_hash   = dhpi_pkg::OUT_W'(h1_q);
  assign res_o.second_hash  = dhpi_pkg::OUT_W'(h2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      acc1_q  <= '0;
      acc2_q  <= '0;
      prod1_q <= '0;
      prod2_q <= '0;
      h1_q    <= '0;
      h2_q    <= '0;
      prodp_q <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= cmd_i.has_byte ? S_MUL : S_FIN_GO;
          end
        end
        S_MUL: begin
          prod1_q <= UW'(acc1_q) * UW'(dhpi_pkg::MULT_FIRST) + UW'(cmd_q.key_byte);
          prod2_q <= UW'(acc2_q) * UW'(dhpi_pkg::MULT_SECOND) + UW'(cmd_q.key_byte);
          state_q <= S_UPD_GO;
        end
        S_UPD_GO: begin
          state_q <= S_UPD_WAIT;
        end
        S_UPD_WAIT: begin
          if (done_a && done_b) begin
            acc1_q  <= rem_a;
            acc2_q  <= rem_b;
            state_q <= cmd_q.is_last ? S_FIN_GO : S_IDLE;
          end
        end
        S_FIN_GO: begin
          state_q <= S_FIN_WAIT;
        end
        S_FIN_WAIT: begin
          if (done_a && done_b) begin
            h1_q    <= rem_a;
            h2_q    <= rem_b;
            acc1_q  <= '0;
            acc2_q  <= '0;
            state_q <= S_PMUL;
          end
        end
        S_PMUL: begin
          prodp_q <= PW'(cmd_q.attempt) * (PW'(h2_q) + PW'(1)) + PW'(h1_q);
          state_q <= S_P_GO;
        end
        S_P_GO: begin
          state_q <= S_P_WAIT;
        end
        S_P_WAIT: begin
          if (done_a) begin
            idx_q   <= rem_a;
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/double_hash_probe_index.sv]
// Top level of the double-hash probe index block: config register and queues.
// Depends on dhpi_pkg, dhpi_front, dhpi_back and dhpi_fifo.
//
//  channel   | signals                                        | transfer when
//  ----------+------------------------------------------------+------------------
//  key in    | push, full, key_byte_i, has_byte_i, is_last_i, | push && !full
//            | attempt_i                                      |
//  result    | empty, pop, bucket_index_o, first_hash_o,      | pop && !empty
//            | second_hash_o                                  |
//  config    | bucket_count_we_i, bucket_count_i              | bucket_count_we_i
//
// Remainders are AW bits wide (AW = min(INDEX_BITS,16)); for a byte item the
// hash update remainder runs one bit per cycle in the serial modulo units.
// A key end adds hash reduction plus probe index reduction.
// Items with neither byte nor key end are dropped at the input.
// Two-entry queues sit on input and output; each side stalls independently.
// Reset clears both hashes and loads 53 into the bucket count; no clearing pass.
module double_hash_probe_index #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [dhpi_pkg::BYTE_W-1:0]         key_byte_i,
  input  logic                                has_byte_i,
  input  logic                                is_last_i,
  input  logic [dhpi_pkg::ATTEMPT_W-1:0]      attempt_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [dhpi_pkg::OUT_W-1:0]          bucket_index_o,
  output logic [dhpi_pkg::OUT_W-1:0]          first_hash_o,
  output logic [dhpi_pkg::OUT_W-1:0]          second_hash_o,
  input  logic                                bucket_count_we_i,
  input  logic [dhpi_pkg::CFG_W-1:0]          bucket_count_i
);

  localparam int unsigned AW = (INDEX_BITS < 16) ? INDEX_BITS : 16;

  logic [dhpi_pkg::CFG_W-1:0]        bucket_count_q;
  logic [AW-1:0]                     m;
  dhpi_pkg::cmd_t                    cmd;
  logic                              cmd_valid, cmd_pop;
  dhpi_pkg::res_t                    res_d, res_q;
  logic [$bits(dhpi_pkg::res_t)-1:0] res_raw;
  logic                              res_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= dhpi_pkg::RESET_BUCKETS;
    end else if (bucket_count_we_i) begin
      bucket_count_q <= bucket_count_i;
    end
  end

  // a bucket count of zero acts as one
  assign m = (bucket_count_q[AW-1:0] == '0) ? AW'(1) : bucket_count_q[AW-1:0];

  dhpi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .key_byte_i  (key_byte_i),
    .has_byte_i  (has_byte_i),
    .is_last_i   (is_last_i),
    .attempt_i   (attempt_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  dhpi_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .m_i         (m),
    .res_o       (res_d),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  dhpi_fifo #(
    .WIDTH ($bits(dhpi_pkg::res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_d),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (res_raw),
    .empty_o   (empty)
  );

  assign res_q          = dhpi_pkg::res_t'(res_raw);
  assign bucket_index_o = res_q.bucket_index;
  assign first_hash_o   = res_q.first_hash;
  assign second_hash_o  = res_q.second_hash;

endmodule
